@@ hdl/websocket_frame_receive_deframer_unit_defines.svh @@
// assertion macros for the websocket receive deframer checker
// no dependencies; included by the checker file only
`ifndef WEBSOCKET_FRAME_RECEIVE_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVE_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define WSFRD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define WSFRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define WSFRD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/wsfrd_pkg.sv @@
// shared types and constants for the websocket receive deframer
// no dependencies; imported by the parser, the result register and the top level
package wsfrd_pkg;

   localparam int LEN_BITS = 64;
   localparam logic [LEN_BITS-1:0] LEN_MASK = {LEN_BITS{1'b1}};

   localparam logic [3:0] OPC_CLOSE   = 4'h8;
   localparam logic [6:0] LEN7_EXT16  = 7'd126;
   localparam logic [6:0] LEN7_EXT64  = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_PAY,
      PH_ERR
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       message_end;
      logic [3:0] lead_opcode;
      logic       close_seen;
      logic       masked_error;
   } result_type;

endpackage

@@ hdl/wsfrd_channel_if.sv @@
// valid/ready channels for the websocket receive deframer
// request carries received bytes, response carries result items
interface wsfrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic       message_end;
   logic [3:0] lead_opcode;
   logic       close_seen;
   logic       masked_error;

   modport source (output valid, output payload_byte, output byte_valid,
                   output message_end, output lead_opcode,
                   output close_seen, output masked_error, input ready);
   modport sink (input valid, input payload_byte, input byte_valid,
                 input message_end, input lead_opcode,
                 input close_seen, input masked_error, output ready);
endinterface

@@ hdl/wsfrd_parser.sv @@
// frame parse state and per-byte result logic
// depends on wsfrd_pkg
module wsfrd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output logic                  emit,
   output wsfrd_pkg::result_type result
);
   import wsfrd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  final_ff, final_in;
   logic [3:0]            opcode_ff, opcode_in;
   logic [LEN_BITS-1:0]   acc_ff, acc_in;
   logic [3:0]            left_ff, left_in;
   logic [LEN_BITS-1:0]   rem_ff, rem_in;
   logic [3:0]            msg_opc_ff, msg_opc_in;
   logic                  inside_ff, inside_in;

   logic                  is_ctrl;
   logic                  is_close;
   logic [6:0]            len7;
   logic                  ext_sat;
   logic [LEN_BITS-1:0]   acc_next;
   logic [3:0]            left_next;
   logic                  known_hdr;
   logic                  known_ext;
   logic [LEN_BITS-1:0]   known_len;
   logic                  known_zero;
   logic                  start_msg;
   logic [3:0]            msg_opc_eff;
   logic [LEN_BITS-1:0]   rem_next;
   logic                  pay_last;

   assign is_ctrl   = opcode_ff[3];
   assign is_close  = (opcode_ff == OPC_CLOSE);
   assign len7      = rx_byte[6:0];
   // saturate once the next shift would overflow the length width
   assign ext_sat   = |acc_ff[LEN_BITS-1 -: 8];
   assign acc_next  = ext_sat ? LEN_MASK : {acc_ff[LEN_BITS-9:0], rx_byte};
   assign left_next = (left_ff != 4'd0) ? left_ff - 4'd1 : 4'd0;
   assign known_hdr = (phase_ff == PH_HDR1) && !rx_byte[7] &&
                      (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64);
   assign known_ext = (phase_ff == PH_EXT) && (left_next == 4'd0);
   assign known_len = known_hdr ? {{(LEN_BITS-7){1'b0}}, len7} : acc_next;
   assign known_zero = (known_len == '0);
   assign start_msg = !is_ctrl && !inside_ff;
   assign msg_opc_eff = start_msg ? opcode_ff : msg_opc_ff;
   assign rem_next  = (rem_ff != '0) ? rem_ff - {{(LEN_BITS-1){1'b0}}, 1'b1} : '0;
   assign pay_last  = (rem_next == '0);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      final_in   = final_ff;
      opcode_in  = opcode_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      rem_in     = rem_ff;
      msg_opc_in = msg_opc_ff;
      inside_in  = inside_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR0: begin
               final_in  = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               acc_in = '0;
               if (rx_byte[7]) begin
                  phase_in = PH_ERR;
               end else if (len7 == LEN7_EXT16) begin
                  left_in  = EXT16_BYTES;
                  phase_in = PH_EXT;
               end else if (len7 == LEN7_EXT64) begin
                  left_in  = EXT64_BYTES;
                  phase_in = PH_EXT;
               end else begin
                  rem_in = known_len;
               end
            end
            PH_EXT: begin
               acc_in  = acc_next;
               left_in = left_next;
               if (known_ext) begin
                  rem_in = known_len;
               end
            end
            PH_PAY: begin
               rem_in = rem_next;
               if (pay_last) begin
                  phase_in = PH_HDR0;
                  if (!is_ctrl && final_ff) begin
                     inside_in = 1'b0;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         // length just became known: open a message if a new data frame starts one, and finish empty frames
         if (known_hdr || known_ext) begin
            if (start_msg) begin
               msg_opc_in = opcode_ff;
               inside_in  = 1'b1;
            end
            if (known_zero) begin
               phase_in = PH_HDR0;
               if (!is_ctrl && final_ff) begin
                  inside_in = 1'b0;
               end
            end else begin
               phase_in = PH_PAY;
            end
         end
      end
   end

   // result for the byte being transferred
   always_comb begin
      emit   = 1'b0;
      result = '0;
      if (accept) begin
         case (phase_ff)
            PH_HDR1, PH_EXT: begin
               if ((phase_ff == PH_HDR1) && rx_byte[7]) begin
                  emit                = 1'b1;
                  result.masked_error = 1'b1;
               end else if ((known_hdr || known_ext) && known_zero) begin
                  if (is_ctrl) begin
                     emit              = is_close;
                     result.close_seen = is_close;
                  end else if (final_ff) begin
                     emit               = 1'b1;
                     result.message_end = 1'b1;
                     result.lead_opcode = msg_opc_eff;
                  end
               end
            end
            PH_PAY: begin
               if (is_ctrl) begin
                  emit              = pay_last && is_close;
                  result.close_seen = pay_last && is_close;
               end else begin
                  emit                = 1'b1;
                  result.payload_byte = rx_byte;
                  result.byte_valid   = 1'b1;
                  result.message_end  = pay_last && final_ff;
                  result.lead_opcode  = msg_opc_ff;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         final_ff   <= 1'b0;
         opcode_ff  <= 4'd0;
         acc_ff     <= '0;
         left_ff    <= 4'd0;
         rem_ff     <= '0;
         msg_opc_ff <= 4'd0;
         inside_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         final_ff   <= final_in;
         opcode_ff  <= opcode_in;
         acc_ff     <= acc_in;
         left_ff    <= left_in;
         rem_ff     <= rem_in;
         msg_opc_ff <= msg_opc_in;
         inside_ff  <= inside_in;
      end
   end

endmodule

@@ hdl/wsfrd_out_reg.sv @@
// result register between the parser and the response channel
// depends on wsfrd_pkg
module wsfrd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  wsfrd_pkg::result_type load_data,
   output logic                  take_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output wsfrd_pkg::result_type out_data
);
   import wsfrd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // a new result may enter when the register is empty or the held one leaves in this cycle
   assign take_ready = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hdl/websocket_frame_receive_deframer_unit.sv @@
// websocket receive deframer: one received byte per transfer, zero or one result each
// a result is registered and is valid in the cycle after the byte that causes it is transferred
// throughput: one byte per cycle while no held result is stalled, set by the parse update and the result register
// reset is synchronous and clears the parse phase, the message state and any held result
// a masked frame reports once, then all later bytes are dropped until reset
module websocket_frame_receive_deframer_unit (
   input logic       clock,
   input logic       reset,
   wsfrd_req_if.sink   req_chan,
   wsfrd_rsp_if.source rsp_chan
);
   import wsfrd_pkg::*;

   logic       accept;
   logic       emit;
   logic       take_ready;
   result_type step_result;
   result_type rsp_data;

   assign req_chan.ready = take_ready;
   assign accept         = req_chan.valid && take_ready;

   wsfrd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .emit    (emit),
      .result  (step_result)
   );

   wsfrd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .load_data  (step_result),
      .take_ready (take_ready),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_data   (rsp_data)
   );

   assign rsp_chan.payload_byte = rsp_data.payload_byte;
   assign rsp_chan.byte_valid   = rsp_data.byte_valid;
   assign rsp_chan.message_end  = rsp_data.message_end;
   assign rsp_chan.lead_opcode  = rsp_data.lead_opcode;
   assign rsp_chan.close_seen   = rsp_data.close_seen;
   assign rsp_chan.masked_error = rsp_data.masked_error;

endmodule

@@ hdl/wsfrd_checker.sv @@
// port-level assertions for the websocket receive deframer, bound to the top level
// depends on websocket_frame_receive_deframer_unit_defines.svh
`include "websocket_frame_receive_deframer_unit_defines.svh"

module wsfrd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_message_end,
   input logic [3:0] rsp_lead_opcode,
   input logic       rsp_close_seen,
   input logic       rsp_masked_error
);

   `WSFRD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid,
      "result dropped while stalled")
   `WSFRD_ASSERT_ALWAYS(a_rsp_reset, reset, !rsp_valid, "result valid after reset")
   `WSFRD_ASSERT_NOW(a_no_data_zero, rsp_valid && !rsp_byte_valid,
      rsp_payload_byte == 8'd0, "payload byte set without data")
   `WSFRD_ASSERT_NOW(a_flag_alone, rsp_valid && (rsp_masked_error || rsp_close_seen),
      !rsp_byte_valid && !rsp_message_end && (rsp_lead_opcode == 4'd0),
      "error or close result carries message fields")

endmodule

bind websocket_frame_receive_deframer_unit wsfrd_checker u_wsfrd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_payload_byte (rsp_chan.payload_byte),
   .rsp_byte_valid   (rsp_chan.byte_valid),
   .rsp_message_end  (rsp_chan.message_end),
   .rsp_lead_opcode  (rsp_chan.lead_opcode),
   .rsp_close_seen   (rsp_chan.close_seen),
   .rsp_masked_error (rsp_chan.masked_error)
);
